// ===== rtl/core/shd_pkg.sv =====
// Shared constants for the saturation humidity tangent-linear/adjoint kernel.
// Used by the channel interfaces and the top level.
`default_nettype none
package shd_pkg;

  localparam int FIELD_W        = 25;  // pressures and ratios
  localparam int ACC_W          = 48;  // perturbations and accumulators
  localparam int PRESS_FRAC_DEF = 8;
  localparam int RATIO_FRAC_DEF = 24;
  localparam int DIV_STEPS      = 3;   // quotient bits per divider stage
  localparam int QSAT_W         = 51;  // second quotient width, anything above saturates

  localparam logic [FIELD_W-1:0] EPS_RESET = 25'd10435428;

  localparam logic [1:0] MODE_NL = 2'd0;
  localparam logic [1:0] MODE_TL = 2'd1;
  localparam logic [1:0] MODE_AD = 2'd2;

  localparam logic [ACC_W-1:0]        ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [QSAT_W-1:0]       AD_LIM  = {1'b1, {(QSAT_W-1){1'b0}}};

endpackage
`default_nettype wire

// ===== rtl/core/shd_ifs.sv =====
// Valid/ready channel interfaces: input items, result items and eps register writes.
// Depends on shd_pkg for field widths.
`default_nettype none
interface shd_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic [shd_pkg::FIELD_W-1:0]       vapor_pressure;
  logic [shd_pkg::FIELD_W-1:0]       air_press;
  logic [shd_pkg::FIELD_W-1:0]       traj_ratio;
  logic signed [shd_pkg::ACC_W-1:0]  vapor_pert;
  logic signed [shd_pkg::ACC_W-1:0]  press_pert;
  logic signed [shd_pkg::ACC_W-1:0]  ratio_adj;
  modport source (output valid, mode, vapor_pressure, air_press, traj_ratio, vapor_pert,
                  press_pert, ratio_adj, input ready);
  modport sink   (input valid, mode, vapor_pressure, air_press, traj_ratio, vapor_pert,
                  press_pert, ratio_adj, output ready);
endinterface

interface shd_out_if;
  logic                              valid;
  logic                              ready;
  logic [shd_pkg::FIELD_W-1:0]       ratio_out;
  logic signed [shd_pkg::ACC_W-1:0]  ratio_pert_out;
  logic signed [shd_pkg::ACC_W-1:0]  vapor_acc_out;
  logic signed [shd_pkg::ACC_W-1:0]  press_acc_out;
  modport source (output valid, ratio_out, ratio_pert_out, vapor_acc_out, press_acc_out,
                  input ready);
  modport sink   (input valid, ratio_out, ratio_pert_out, vapor_acc_out, press_acc_out,
                  output ready);
endinterface

interface shd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [shd_pkg::FIELD_W-1:0] eps_ratio;
  modport source (output valid, eps_ratio, input ready);
  modport sink   (input valid, eps_ratio, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/shd_divpipe.sv =====
// Pipelined restoring divider lane, STEPS quotient bits per stage, per-stage enables.
// Self-contained; the top level supplies stage enables and operands.
`default_nettype none
module shd_divpipe #(
  parameter int UW    = 51,
  parameter int QW    = 66,
  parameter int STEPS = 3,
  localparam int NST  = (QW + STEPS - 1) / STEPS
) (
  input  logic          clk,
  input  logic [NST-1:0] en,
  input  logic [UW-1:0] rem_i,
  input  logic [QW-1:0] qd_i,
  input  logic [UW-1:0] den_i,
  output logic [QW-1:0] q_o,
  output logic [UW-1:0] den_o
);

  logic [UW-1:0] rem_r [NST];
  logic [QW-1:0] qd_r  [NST];
  logic [UW-1:0] den_r [NST];

  for (genvar st = 0; st < NST; st++) begin : g_st
    logic [UW-1:0] rem_s, den_s, rem_nxt;
    logic [QW-1:0] qd_s, qd_nxt;
    logic [UW:0]   trial;

    if (st == 0) begin : g_first
      assign rem_s = rem_i;
      assign qd_s  = qd_i;
      assign den_s = den_i;
    end else begin : g_next
      assign rem_s = rem_r[st-1];
      assign qd_s  = qd_r[st-1];
      assign den_s = den_r[st-1];
    end

    // dividend bits leave at the top of qd, quotient bits enter at the bottom
    always_comb begin
      rem_nxt = rem_s;
      qd_nxt  = qd_s;
      trial   = '0;
      for (int s = 0; s < STEPS; s++) begin
        if (st * STEPS + s < QW) begin
          trial  = {rem_nxt, qd_nxt[QW-1]};
          qd_nxt = {qd_nxt[QW-2:0], 1'b0};
          if (trial >= {1'b0, den_s}) begin
            rem_nxt   = UW'(trial - {1'b0, den_s});
            qd_nxt[0] = 1'b1;
          end else begin
            rem_nxt = trial[UW-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[st]) begin
        rem_r[st] <= rem_nxt;
        qd_r[st]  <= qd_nxt;
        den_r[st] <= den_s;
      end
    end
  end

  assign q_o   = qd_r[NST-1];
  assign den_o = den_r[NST-1];

endmodule
`default_nettype wire

// ===== rtl/core/saturation_humidity_tl_ad_top.sv =====
// Saturation specific humidity kernel, nonlinear / tangent-linear / adjoint, fully pipelined.
// Depends on shd_pkg, shd_ifs (channels) and shd_divpipe (divider lanes).
//
// One item is accepted per cycle while in_ch.ready is high, and each item gives one
// result. Most of the stages are the two chained restoring dividers, each lane
// resolving three quotient bits per stage. Stages hold independently, so a stalled
// result only stops the stages behind it once they are full; bubbles ahead are squeezed
// out and requests keep being taken while a bubble remains. The eps register is written
// at any time the port requests and is read live, so write it only while no items are
// in flight.
`default_nettype none
module saturation_humidity_tl_ad_top #(
  parameter int PRESS_FRAC_BITS = shd_pkg::PRESS_FRAC_DEF,
  parameter int RATIO_FRAC_BITS = shd_pkg::RATIO_FRAC_DEF
) (
  input  logic clk,
  input  logic rst_n,
  shd_in_if.sink    in_ch,
  shd_out_if.source out_ch,
  shd_cfg_if.sink   cfg_ch
);

  localparam int FW    = shd_pkg::FIELD_W;
  localparam int AW    = shd_pkg::ACC_W;
  localparam int HALF  = AW / 2;
  localparam int R     = RATIO_FRAC_BITS;
  localparam int K     = PRESS_FRAC_BITS + RATIO_FRAC_BITS;
  localparam int DW    = ((R + FW > 2 * FW) ? R + FW : 2 * FW) + 2;
  localparam int UW    = DW - 1;
  localparam int NW    = AW + FW + 1;
  localparam int NC    = (NW + FW - 1) / FW;
  localparam int XW    = NW + FW;
  localparam int Q1W   = XW - K;
  localparam int Q2W   = shd_pkg::QSAT_W;
  localparam int SH    = Q2W - K;
  localparam int CW    = ((Q1W > UW + SH) ? Q1W : UW + SH) + 1;
  localparam int STEPS = shd_pkg::DIV_STEPS;
  localparam int ND1   = (Q1W + STEPS - 1) / STEPS;
  localparam int ND2   = (Q2W + STEPS - 1) / STEPS;
  localparam int SW    = Q2W + 2;

  localparam int S_IN   = 0;
  localparam int S_MAG  = 1;
  localparam int S_PP   = 2;
  localparam int S_DEN  = 3;
  localparam int S_NUM  = 4;
  localparam int S_EPP  = 5;
  localparam int S_X    = 6;
  localparam int S_D1   = 7;
  localparam int S_MID  = S_D1 + ND1;
  localparam int S_D2   = S_MID + 1;
  localparam int S_POST = S_D2 + ND2;
  localparam int N      = S_POST + 1;

  typedef struct packed {
    logic [1:0]           mode;
    logic [FW-1:0]        svp;
    logic [FW-1:0]        prs;
    logic [FW-1:0]        traj;
    logic signed [AW-1:0] vp;
    logic signed [AW-1:0] pp;
    logic                 ra_neg;
  } front_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic                 den_ok;
    logic                 live;
    logic                 ratio_full;
    logic                 neg;
    logic                 ra_neg;
    logic                 ovf_a;
    logic                 ovf_b;
    logic [FW-1:0]        ratio;
    logic signed [AW-1:0] vp;
    logic signed [AW-1:0] pp;
  } side_t;

  // ---------------- configuration ----------------
  logic [FW-1:0] eps_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= shd_pkg::EPS_RESET;
    end else if (cfg_ch.valid) begin
      eps_r <= cfg_ch.eps_ratio;
    end
  end

  // ---------------- stage valids and enables ----------------
  logic [N-1:0] vld_r;
  logic [N-1:0] en;

  assign en[N-1] = ~vld_r[N-1] | out_ch.ready;
  for (genvar g = 0; g < N - 1; g++) begin : g_en
    assign en[g] = ~vld_r[g] | en[g+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (en[i]) vld_r[i] <= (i == 0) ? in_ch.valid : vld_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign in_ch.ready = en[S_IN];

  // ---------------- stage 0: input register ----------------
  logic [1:0]           mode0_r;
  logic [FW-1:0]        svp0_r, prs0_r, traj0_r;
  logic signed [AW-1:0] vp0_r, pp0_r, ra0_r;

  always_ff @(posedge clk) begin
    if (en[S_IN]) begin
      mode0_r <= in_ch.mode;
      svp0_r  <= in_ch.vapor_pressure;
      prs0_r  <= in_ch.air_press;
      traj0_r <= in_ch.traj_ratio;
      vp0_r   <= in_ch.vapor_pert;
      pp0_r   <= in_ch.press_pert;
      ra0_r   <= in_ch.ratio_adj;
    end
  end

  // ---------------- stage 1: magnitudes ----------------
  front_t      f1_r, f1_nxt;
  logic [AW-1:0] ma1_r, mb1_r, ma1_nxt, mb1_nxt;
  logic [AW-1:0] mag_vp, mag_pp, mag_ra;

  always_comb begin
    mag_vp = vp0_r[AW-1] ? (~vp0_r + 1'b1) : vp0_r;
    mag_pp = pp0_r[AW-1] ? (~pp0_r + 1'b1) : pp0_r;
    mag_ra = ra0_r[AW-1] ? (~ra0_r + 1'b1) : ra0_r;
    // adjoint scales the ratio adjoint, tangent linear the two perturbations
    ma1_nxt = (mode0_r == shd_pkg::MODE_AD) ? mag_ra : mag_vp;
    mb1_nxt = (mode0_r == shd_pkg::MODE_AD) ? mag_ra : mag_pp;
    f1_nxt.mode   = mode0_r;
    f1_nxt.svp    = svp0_r;
    f1_nxt.prs    = prs0_r;
    f1_nxt.traj   = traj0_r;
    f1_nxt.vp     = vp0_r;
    f1_nxt.pp     = pp0_r;
    f1_nxt.ra_neg = ra0_r[AW-1];
  end

  always_ff @(posedge clk) begin
    if (en[S_MAG]) begin
      f1_r  <= f1_nxt;
      ma1_r <= ma1_nxt;
      mb1_r <= mb1_nxt;
    end
  end

  // ---------------- stage 2: partial products ----------------
  front_t              f2_r;
  logic [HALF+FW-1:0]  pal2_r, pah2_r, pbl2_r, pbh2_r;
  logic [2*FW-1:0]     es2_r;

  always_ff @(posedge clk) begin
    if (en[S_PP]) begin
      f2_r   <= f1_r;
      pal2_r <= ma1_r[HALF-1:0] * f1_r.prs;
      pah2_r <= ma1_r[AW-1:HALF] * f1_r.prs;
      pbl2_r <= mb1_r[HALF-1:0] * f1_r.svp;
      pbh2_r <= mb1_r[AW-1:HALF] * f1_r.svp;
      es2_r  <= eps_r * f1_r.svp;
    end
  end

  // ---------------- stage 3: products and denominator ----------------
  front_t               f3_r;
  logic [NW-1:0]        pa3_r, pb3_r, pa3_nxt, pb3_nxt;
  logic [2*FW-1:0]      es3_r;
  logic signed [DW-1:0] den3_r, den3_nxt;
  logic                 den_ok3_r, live3_r, den_ok3_nxt, live3_nxt;

  always_comb begin
    pa3_nxt  = (NW'(pah2_r) << HALF) + NW'(pal2_r);
    pb3_nxt  = (NW'(pbh2_r) << HALF) + NW'(pbl2_r);
    den3_nxt = $signed(DW'(f2_r.prs) << R) - $signed(DW'(f2_r.svp) << R)
             + $signed(DW'(es2_r));
    den_ok3_nxt = den3_nxt > $signed(DW'(1) << K);
    live3_nxt   = den_ok3_nxt && (f2_r.traj != '0)
               && (32'(f2_r.traj) < (32'd1 << R));
  end

  always_ff @(posedge clk) begin
    if (en[S_DEN]) begin
      f3_r      <= f2_r;
      pa3_r     <= pa3_nxt;
      pb3_r     <= pb3_nxt;
      es3_r     <= es2_r;
      den3_r    <= den3_nxt;
      den_ok3_r <= den_ok3_nxt;
      live3_r   <= live3_nxt;
    end
  end

  // ---------------- stage 4: numerators ----------------
  logic [NW-1:0] na4_r, nb4_r, na4_nxt, ntl;
  logic [UW-1:0] den4_r;
  side_t         sd4_nxt;
  logic          an, bn, ntl_neg;

  always_comb begin
    an = f3_r.vp[AW-1];
    bn = ~f3_r.pp[AW-1];
    if (an == bn) begin
      ntl     = pa3_r + pb3_r;
      ntl_neg = an;
    end else if (pa3_r >= pb3_r) begin
      ntl     = pa3_r - pb3_r;
      ntl_neg = an;
    end else begin
      ntl     = pb3_r - pa3_r;
      ntl_neg = bn;
    end
    case (f3_r.mode)
      shd_pkg::MODE_NL: na4_nxt = NW'(f3_r.svp) << R;   // times eps gives es << R
      shd_pkg::MODE_TL: na4_nxt = ntl;
      default:          na4_nxt = pa3_r;
    endcase
    sd4_nxt.mode       = f3_r.mode;
    sd4_nxt.den_ok     = den_ok3_r;
    sd4_nxt.live       = live3_r;
    sd4_nxt.ratio_full = $signed(DW'(es3_r)) >= den3_r;
    sd4_nxt.neg        = ntl_neg;
    sd4_nxt.ra_neg     = f3_r.ra_neg;
    sd4_nxt.ovf_a      = 1'b0;
    sd4_nxt.ovf_b      = 1'b0;
    sd4_nxt.ratio      = '0;
    sd4_nxt.vp         = f3_r.vp;
    sd4_nxt.pp         = f3_r.pp;
  end

  always_ff @(posedge clk) begin
    if (en[S_NUM]) begin
      na4_r  <= na4_nxt;
      nb4_r  <= pb3_r;
      den4_r <= den3_r[UW-1:0];
    end
  end

  // ---------------- stage 5: eps times numerator, partial products ----------------
  logic [NC*FW-1:0] na_pad, nb_pad;
  logic [2*FW-1:0]  pa5_r [NC];
  logic [2*FW-1:0]  pb5_r [NC];
  logic [UW-1:0]    den5_r;

  assign na_pad = (NC*FW)'(na4_r);
  assign nb_pad = (NC*FW)'(nb4_r);

  always_ff @(posedge clk) begin
    if (en[S_EPP]) begin
      for (int c = 0; c < NC; c++) begin
        pa5_r[c] <= eps_r * na_pad[c*FW +: FW];
        pb5_r[c] <= eps_r * nb_pad[c*FW +: FW];
      end
      den5_r <= den4_r;
    end
  end

  // ---------------- stage 6: first dividend ----------------
  logic [XW-1:0] xa6_r, xb6_r, xa_nxt, xb_nxt;
  logic [UW-1:0] den6_r;

  always_comb begin
    xa_nxt = '0;
    xb_nxt = '0;
    for (int c = 0; c < NC; c++) begin
      xa_nxt = xa_nxt + (XW'(pa5_r[c]) << (c * FW));
      xb_nxt = xb_nxt + (XW'(pb5_r[c]) << (c * FW));
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_X]) begin
      xa6_r  <= xa_nxt;
      xb6_r  <= xb_nxt;
      den6_r <= den5_r;
    end
  end

  // ---------------- first division: eps * n / den ----------------
  logic [Q1W-1:0] q1a, q1b;
  logic [UW-1:0]  den_d1;

  shd_divpipe #(.UW(UW), .QW(Q1W), .STEPS(STEPS)) u_d1a (
    .clk   (clk),
    .en    (en[S_D1 +: ND1]),
    .rem_i (UW'(xa6_r >> Q1W)),
    .qd_i  (xa6_r[Q1W-1:0]),
    .den_i (den6_r),
    .q_o   (q1a),
    .den_o (den_d1)
  );

  shd_divpipe #(.UW(UW), .QW(Q1W), .STEPS(STEPS)) u_d1b (
    .clk   (clk),
    .en    (en[S_D1 +: ND1]),
    .rem_i (UW'(xb6_r >> Q1W)),
    .qd_i  (xb6_r[Q1W-1:0]),
    .den_i (den6_r),
    .q_o   (q1b),
    .den_o ()
  );

  // ---------------- mid stage: overflow check, second dividend ----------------
  logic           ovf_a_c, ovf_b_c;
  logic [UW-1:0]  rema_m_r, remb_m_r, den_m_r;
  logic [Q2W-1:0] qda_m_r, qdb_m_r;

  // the second quotient saturates when q1 * 2^K reaches den * 2^Q2W
  assign ovf_a_c = CW'(q1a) >= (CW'(den_d1) << SH);
  assign ovf_b_c = CW'(q1b) >= (CW'(den_d1) << SH);

  always_ff @(posedge clk) begin
    if (en[S_MID]) begin
      rema_m_r <= UW'(q1a >> SH);
      remb_m_r <= UW'(q1b >> SH);
      qda_m_r  <= {q1a[SH-1:0], {K{1'b0}}};
      qdb_m_r  <= {q1b[SH-1:0], {K{1'b0}}};
      den_m_r  <= den_d1;
    end
  end

  // ---------------- second division: q1 * 2^K / den ----------------
  logic [Q2W-1:0] q2a, q2b;

  shd_divpipe #(.UW(UW), .QW(Q2W), .STEPS(STEPS)) u_d2a (
    .clk   (clk),
    .en    (en[S_D2 +: ND2]),
    .rem_i (rema_m_r),
    .qd_i  (qda_m_r),
    .den_i (den_m_r),
    .q_o   (q2a),
    .den_o ()
  );

  shd_divpipe #(.UW(UW), .QW(Q2W), .STEPS(STEPS)) u_d2b (
    .clk   (clk),
    .en    (en[S_D2 +: ND2]),
    .rem_i (remb_m_r),
    .qd_i  (qdb_m_r),
    .den_i (den_m_r),
    .q_o   (q2b),
    .den_o ()
  );

  // ---------------- sideband alongside the dividers ----------------
  side_t sd_r [S_NUM:S_POST-1];

  for (genvar i = S_NUM; i < S_POST; i++) begin : g_sd
    side_t sd_in;
    if (i == S_NUM) begin : g_head
      assign sd_in = sd4_nxt;
    end else if (i == S_MID) begin : g_mid
      always_comb begin
        sd_in       = sd_r[i-1];
        sd_in.ovf_a = ovf_a_c;
        sd_in.ovf_b = ovf_b_c;
        sd_in.ratio = q1a[FW-1:0];
      end
    end else begin : g_pass
      assign sd_in = sd_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en[i]) sd_r[i] <= sd_in;
    end
  end

  // ---------------- final stage: saturate, sign, accumulate ----------------
  side_t                sdp;
  logic [AW-1:0]        tl_mag;
  logic [Q2W-1:0]       ds, dp;
  logic signed [SW-1:0] dsx, dpx, vsum, psum;
  logic signed [SW-1:0] smax, smin;
  logic [FW-1:0]        ratio_nxt;
  logic signed [AW-1:0] pert_nxt, vacc_nxt, pacc_nxt;
  logic [FW-1:0]        ratio_r;
  logic signed [AW-1:0] pert_r, vacc_r, pacc_r;

  assign sdp  = sd_r[S_POST-1];
  assign smax = $signed(SW'(shd_pkg::ACC_MAX));
  assign smin = SW'(shd_pkg::ACC_MIN);

  always_comb begin
    tl_mag = (sdp.ovf_a || (q2a > Q2W'(shd_pkg::ACC_MAX))) ? shd_pkg::ACC_MAX : q2a[AW-1:0];
    ds     = (sdp.ovf_a || (q2a > shd_pkg::AD_LIM)) ? shd_pkg::AD_LIM : q2a;
    dp     = (sdp.ovf_b || (q2b > shd_pkg::AD_LIM)) ? shd_pkg::AD_LIM : q2b;
    dsx    = $signed({2'b00, ds});
    dpx    = $signed({2'b00, dp});
    // vapor term takes the sign of the ratio adjoint, pressure term the opposite
    vsum   = SW'(sdp.vp) + (sdp.ra_neg ? -dsx : dsx);
    psum   = SW'(sdp.pp) + (sdp.ra_neg ? dpx : -dpx);

    ratio_nxt = '0;
    pert_nxt  = '0;
    vacc_nxt  = sdp.vp;
    pacc_nxt  = sdp.pp;
    case (sdp.mode)
      shd_pkg::MODE_NL: begin
        if (sdp.den_ok) ratio_nxt = sdp.ratio_full ? FW'(64'd1 << R) : sdp.ratio;
      end
      shd_pkg::MODE_TL: begin
        if (sdp.live) pert_nxt = sdp.neg ? -$signed(tl_mag) : $signed(tl_mag);
      end
      shd_pkg::MODE_AD: begin
        if (sdp.live) begin
          vacc_nxt = (vsum > smax) ? $signed(shd_pkg::ACC_MAX) :
                     (vsum < smin) ? shd_pkg::ACC_MIN : AW'(vsum);
          pacc_nxt = (psum > smax) ? $signed(shd_pkg::ACC_MAX) :
                     (psum < smin) ? shd_pkg::ACC_MIN : AW'(psum);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[S_POST]) begin
      ratio_r <= ratio_nxt;
      pert_r  <= pert_nxt;
      vacc_r  <= vacc_nxt;
      pacc_r  <= pacc_nxt;
    end
  end

  assign out_ch.valid          = vld_r[N-1];
  assign out_ch.ratio_out      = ratio_r;
  assign out_ch.ratio_pert_out = pert_r;
  assign out_ch.vapor_acc_out  = vacc_r;
  assign out_ch.press_acc_out  = pacc_r;

endmodule
`default_nettype wire
